@@ src/mbrm_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrm_pkg
// Shared types, codes and the CRC-16/Modbus byte update for the read-holding-
// registers master.
// ----------------------------------------------------------------------------
package mbrm_pkg;

    // item selector codes on the input tuser
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // result kind on the output tuser
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // report status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;

    // configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_FUNC_CODE  = 1'b1;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
    localparam logic [7:0]  FUNC_CODE_RST  = 8'h03;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FRAME_PAD      = 8'h00;
    localparam logic [3:0]  RSP_BASE_LEN   = 4'd5;

    // frame byte positions
    localparam logic [2:0] FB_ADDR    = 3'd0;
    localparam logic [2:0] FB_FUNC    = 3'd1;
    localparam logic [2:0] FB_REG_HI  = 3'd2;
    localparam logic [2:0] FB_REG_LO  = 3'd3;
    localparam logic [2:0] FB_PAD     = 3'd4;
    localparam logic [2:0] FB_COUNT   = 3'd5;
    localparam logic [2:0] FB_CRC_LO  = 3'd6;
    localparam logic [2:0] FB_CRC_HI  = 3'd7;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [31:0] value;
    } t_rpt;

    typedef struct packed {
        logic       busy;
        logic [7:0] data;
        logic       last;
    } t_tx;

    // one byte of CRC-16/Modbus, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/modbus_rtu_read_regs_master_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_regs_master_unit
// Modbus RTU master for read holding registers, one or two registers.
//
// Input stream: tuser carries the item kind (start request, received byte,
// receive timeout). A start item produces eight transmit beats (address,
// function, start register, 0x00, count, crc low, crc high; tlast on the
// eighth) and arms the receiver. Received bytes are counted; when the
// expected length is in, one report beat comes out with status ok and the
// value, or crc mismatch. A timeout while armed gives a timeout report.
// Output beats have tuser = 0 for transmit bytes and 1 for reports.
// The first transmit byte passes the sequencer state and the output register;
// a report goes straight to the output register unless it must park first.
// Throughput: items with at most one result are taken every cycle; a start
// item occupies the frame sequencer for eight output beats, so the next
// start (or any item while a report is parked) waits for that drain.
// Reset clears the receiver (idle), the sequencer and both configuration
// registers to address 1 and function 3. When the output receiver stalls,
// the output register holds its beat and one report can park behind it.
// ----------------------------------------------------------------------------
module modbus_rtu_read_regs_master_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // first_reg[15:0], num_regs[17:16], rx_byte[25:18]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // tx_byte[7:0], status[9:8], value[41:10]
    output logic        o_m_axis_tuser,   // kind[0]
    output logic        o_m_axis_tlast
);

    logic [7:0]  r_slave_addr;
    logic [7:0]  r_func_code;

    logic [1:0]  in_op;
    logic [15:0] in_first_reg;
    logic [1:0]  in_num_regs;
    logic [7:0]  in_rx_byte;
    logic        s_acc;
    logic        tx_start;

    mbrm_pkg::t_tx  tx;
    mbrm_pkg::t_rpt rpt;

    logic        r_rpt_valid;
    logic [1:0]  r_rpt_status;
    logic [31:0] r_rpt_value;

    logic        r_m_valid, n_m_valid;
    logic        r_m_kind, n_m_kind;
    logic [7:0]  r_m_byte, n_m_byte;
    logic        r_m_last, n_m_last;
    logic [1:0]  r_m_status, n_m_status;
    logic [31:0] r_m_value, n_m_value;

    logic        out_free;
    logic        tx_adv;
    logic        rpt_from_reg;
    logic        rpt_direct;

    assign in_op        = i_s_axis_tuser;
    assign in_first_reg = i_s_axis_tdata[15:0];
    assign in_num_regs  = i_s_axis_tdata[17:16];
    assign in_rx_byte   = i_s_axis_tdata[25:18];

    // a parked report blocks everything; a start also waits for the sequencer
    assign o_s_axis_tready = !r_rpt_valid && !(tx.busy && in_op == mbrm_pkg::OP_START);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign tx_start        = s_acc && in_op == mbrm_pkg::OP_START;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= mbrm_pkg::SLAVE_ADDR_RST;
            r_func_code  <= mbrm_pkg::FUNC_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mbrm_pkg::CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_wdata;
                mbrm_pkg::CFG_FUNC_CODE:  r_func_code  <= i_cfg_wdata;
                default:                  r_slave_addr <= r_slave_addr;
            endcase
        end
    end

    mbrm_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (tx_start),
        .i_slave_addr (r_slave_addr),
        .i_func_code  (r_func_code),
        .i_first_reg  (in_first_reg),
        .i_num_regs   (in_num_regs),
        .i_adv        (tx_adv),
        .o_tx         (tx)
    );

    mbrm_rx u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (s_acc),
        .i_op        (in_op),
        .i_num_regs  (in_num_regs),
        .i_rx_byte   (in_rx_byte),
        .o_rpt       (rpt)
    );

    // frame bytes first, then a parked report, then a fresh one
    assign out_free     = !r_m_valid || i_m_axis_tready;
    assign tx_adv       = tx.busy && out_free;
    assign rpt_from_reg = !tx.busy && r_rpt_valid && out_free;
    assign rpt_direct   = !tx.busy && !r_rpt_valid && rpt.valid && out_free;

    always_comb begin
        n_m_valid  = r_m_valid;
        n_m_kind   = r_m_kind;
        n_m_byte   = r_m_byte;
        n_m_last   = r_m_last;
        n_m_status = r_m_status;
        n_m_value  = r_m_value;
        priority if (tx_adv) begin
            n_m_valid  = 1'b1;
            n_m_kind   = mbrm_pkg::KIND_TX;
            n_m_byte   = tx.data;
            n_m_last   = tx.last;
            n_m_status = mbrm_pkg::ST_OK;
            n_m_value  = '0;
        end else if (rpt_from_reg) begin
            n_m_valid  = 1'b1;
            n_m_kind   = mbrm_pkg::KIND_REPORT;
            n_m_byte   = 8'h00;
            n_m_last   = 1'b1;
            n_m_status = r_rpt_status;
            n_m_value  = r_rpt_value;
        end else if (rpt_direct) begin
            n_m_valid  = 1'b1;
            n_m_kind   = mbrm_pkg::KIND_REPORT;
            n_m_byte   = 8'h00;
            n_m_last   = 1'b1;
            n_m_status = rpt.status;
            n_m_value  = rpt.value;
        end else if (i_m_axis_tready) begin
            n_m_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_rpt_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            if (rpt.valid && !rpt_direct) begin
                r_rpt_valid <= 1'b1;
            end else if (rpt_from_reg) begin
                r_rpt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_kind   <= n_m_kind;
        r_m_byte   <= n_m_byte;
        r_m_last   <= n_m_last;
        r_m_status <= n_m_status;
        r_m_value  <= n_m_value;
        if (rpt.valid && !rpt_direct) begin
            r_rpt_status <= rpt.status;
            r_rpt_value  <= rpt.value;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {6'b0, r_m_value, r_m_status, r_m_byte};
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;

    // an accepted start keeps the sequencer busy in the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_start |=> tx.busy)
        else $error("start taken but sequencer idle");

    // a new report never lands while one is already parked
    a_no_rpt_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rpt_valid |-> !rpt.valid)
        else $error("report lost behind parked report");

    // a report beat is always marked last
    a_rpt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_kind == mbrm_pkg::KIND_REPORT |-> r_m_last)
        else $error("report beat without tlast");

endmodule

@@ src/mbrm_tx.sv @@
// ----------------------------------------------------------------------------
// mbrm_tx
// Request frame sequencer: walks the eight frame bytes one per output beat
// and folds each header byte into the frame CRC as it goes out.
// ----------------------------------------------------------------------------
module mbrm_tx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_slave_addr,
    input  logic [7:0]  i_func_code,
    input  logic [15:0] i_first_reg,
    input  logic [1:0]  i_num_regs,
    input  logic        i_adv,
    output mbrm_pkg::t_tx o_tx
);

    logic        r_busy, n_busy;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_addr;
    logic [7:0]  r_func;
    logic [15:0] r_reg;
    logic [1:0]  r_cnt;
    logic [7:0]  cur_byte;

    always_comb begin
        unique case (r_idx)
            mbrm_pkg::FB_ADDR:   cur_byte = r_addr;
            mbrm_pkg::FB_FUNC:   cur_byte = r_func;
            mbrm_pkg::FB_REG_HI: cur_byte = r_reg[15:8];
            mbrm_pkg::FB_REG_LO: cur_byte = r_reg[7:0];
            mbrm_pkg::FB_PAD:    cur_byte = mbrm_pkg::FRAME_PAD;
            mbrm_pkg::FB_COUNT:  cur_byte = {6'b0, r_cnt};
            mbrm_pkg::FB_CRC_LO: cur_byte = r_crc[7:0];
            mbrm_pkg::FB_CRC_HI: cur_byte = r_crc[15:8];
            default:             cur_byte = mbrm_pkg::FRAME_PAD;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_crc  = r_crc;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = mbrm_pkg::FB_ADDR;
            n_crc  = mbrm_pkg::CRC_INIT;
        end else if (r_busy && i_adv) begin
            // crc bytes themselves are not folded in
            if (r_idx != mbrm_pkg::FB_CRC_LO && r_idx != mbrm_pkg::FB_CRC_HI) begin
                n_crc = mbrm_pkg::crc_byte(r_crc, cur_byte);
            end
            n_idx = r_idx + 3'd1;
            if (r_idx == mbrm_pkg::FB_CRC_HI) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= mbrm_pkg::FB_ADDR;
            r_crc  <= mbrm_pkg::CRC_INIT;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_crc  <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr <= i_slave_addr;
            r_func <= i_func_code;
            r_reg  <= i_first_reg;
            r_cnt  <= i_num_regs;
        end
    end

    assign o_tx.busy = r_busy;
    assign o_tx.data = cur_byte;
    assign o_tx.last = (r_idx == mbrm_pkg::FB_CRC_HI);

    // a new frame never starts on top of one still going out
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("frame start while sequencer busy");

    // the sequencer only stops after the high crc byte
    a_stop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_idx) == mbrm_pkg::FB_CRC_HI && $past(i_adv))
        else $error("frame cut short");

    // index only moves on an output beat or at a start
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_adv && !i_start |=> $stable(r_idx))
        else $error("frame index moved without a beat");

endmodule

@@ src/mbrm_rx.sv @@
// ----------------------------------------------------------------------------
// mbrm_rx
// Response receiver: counts response bytes, runs the CRC two bytes behind,
// captures the data bytes and raises a report at the end or on timeout.
// ----------------------------------------------------------------------------
module mbrm_rx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_num_regs,
    input  logic [7:0]  i_rx_byte,
    output mbrm_pkg::t_rpt o_rpt
);

    logic        r_waiting, n_waiting;
    logic [3:0]  r_exp_len, n_exp_len;
    logic [3:0]  r_rcv_cnt, n_rcv_cnt;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_held, n_held;
    logic [31:0] r_data, n_data;
    logic        r_wide, n_wide;

    always_comb begin
        n_waiting = r_waiting;
        n_exp_len = r_exp_len;
        n_rcv_cnt = r_rcv_cnt;
        n_crc     = r_crc;
        n_held    = r_held;
        n_data    = r_data;
        n_wide    = r_wide;
        o_rpt     = '0;
        if (i_acc) begin
            unique case (i_op)
                mbrm_pkg::OP_START: begin
                    n_waiting = 1'b1;
                    n_exp_len = mbrm_pkg::RSP_BASE_LEN + {1'b0, i_num_regs, 1'b0};
                    n_rcv_cnt = 4'd0;
                    n_crc     = mbrm_pkg::CRC_INIT;
                    n_held    = '0;
                    n_data    = '0;
                    n_wide    = (i_num_regs == 2'd2);
                end
                mbrm_pkg::OP_RX_BYTE: begin
                    if (r_waiting) begin
                        // crc trails by two bytes so the last two are the check
                        if (r_rcv_cnt >= 4'd2) begin
                            n_crc = mbrm_pkg::crc_byte(r_crc, r_held[15:8]);
                        end
                        n_held = {r_held[7:0], i_rx_byte};
                        unique case (r_rcv_cnt)
                            4'd3:    n_data[31:24] = i_rx_byte;
                            4'd4:    n_data[23:16] = i_rx_byte;
                            4'd5:    n_data[15:8]  = i_rx_byte;
                            4'd6:    n_data[7:0]   = i_rx_byte;
                            default: n_data        = r_data;
                        endcase
                        n_rcv_cnt = r_rcv_cnt + 4'd1;
                        if (n_rcv_cnt == r_exp_len) begin
                            n_waiting   = 1'b0;
                            o_rpt.valid = 1'b1;
                            // check bytes arrive low byte first
                            if ({i_rx_byte, r_held[7:0]} != n_crc) begin
                                o_rpt.status = mbrm_pkg::ST_CRC_ERR;
                            end else begin
                                o_rpt.status = mbrm_pkg::ST_OK;
                                o_rpt.value  = r_wide ? n_data : {16'h0000, n_data[31:16]};
                            end
                        end
                    end
                end
                mbrm_pkg::OP_TIMEOUT: begin
                    if (r_waiting) begin
                        n_waiting    = 1'b0;
                        o_rpt.valid  = 1'b1;
                        o_rpt.status = mbrm_pkg::ST_TIMEOUT;
                    end
                end
                default: begin
                    n_waiting = r_waiting;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_exp_len <= 4'd0;
            r_rcv_cnt <= 4'd0;
            r_crc     <= mbrm_pkg::CRC_INIT;
            r_held    <= '0;
            r_data    <= '0;
            r_wide    <= 1'b0;
        end else begin
            r_waiting <= n_waiting;
            r_exp_len <= n_exp_len;
            r_rcv_cnt <= n_rcv_cnt;
            r_crc     <= n_crc;
            r_held    <= n_held;
            r_data    <= n_data;
            r_wide    <= n_wide;
        end
    end

    // a report only comes out of an outstanding request
    a_rpt_needs_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rpt.valid |-> r_waiting)
        else $error("report without outstanding request");

    // the byte count never reaches the expected length while still waiting
    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> r_rcv_cnt < r_exp_len)
        else $error("receive count overran expected length");

    // a report closes the outstanding request
    a_rpt_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rpt.valid |=> !r_waiting)
        else $error("request still open after report");

endmodule
